>>> design/mvr_pkg.sv
// Package for the mesh vertex ring builder: operation, status and state codes,
// plus the command record shared by the front, back and top level and the result record of the back end.
// Depends on nothing.
package mvr_pkg;

   localparam logic [2:0] FUNC_LOAD    = 3'd0;
   localparam logic [2:0] FUNC_BUILD   = 3'd1;
   localparam logic [2:0] FUNC_RD_VERT = 3'd2;
   localparam logic [2:0] FUNC_RD_FACE = 3'd3;
   localparam logic [2:0] FUNC_RD_NB   = 3'd4;
   localparam logic [2:0] FUNC_CLEAR   = 3'd5;

   localparam logic [31:0] TRI_MARK = 32'hffff_ffff;

   typedef enum logic [2:0] {
      OP_LOAD, OP_BUILD, OP_RD_VERT, OP_RD_FACE, OP_RD_NB, OP_CLEAR, OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK, STAT_FULL, STAT_RANGE, STAT_NOT_BUILT
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_RD_ISSUE, ST_RD_DATA, ST_CLR, ST_FACE_RD, ST_OP_RD,
      ST_OP_WR, ST_PFX_RD, ST_PFX_WR, ST_DD_RD, ST_DD_LATCH, ST_MK_RD, ST_MK_WR,
      ST_SC_RD, ST_SC_WR, ST_DD_WR, ST_FIN
   } bld_state_type;

   typedef enum logic [1:0] {
      P_FCOUNT, P_FFILL, P_RCOUNT, P_RFILL
   } pass_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] corner_a;
      logic [31:0] corner_b;
      logic [31:0] corner_c;
      logic [31:0] corner_d;
      logic [12:0] read_index;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [12:0] face_start;
      logic [12:0] face_count;
      logic [13:0] neighbor_start;
      logic [13:0] neighbor_count;
      logic        on_edge;
      logic [9:0]  ring_entry;
      logic [12:0] face_total;
      logic [13:0] neighbor_total;
   } res_type;

endpackage

>>> design/mvr_chan_if.sv
// Request and result channel interfaces of the mesh vertex ring builder.
// Each carries valid, ready and the payload fields; no package dependency.
interface mvr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] corner_a;
   logic [31:0] corner_b;
   logic [31:0] corner_c;
   logic [31:0] corner_d;
   logic [12:0] read_index;

   modport source (output valid, func, corner_a, corner_b, corner_c, corner_d,
                   read_index, input ready);
   modport sink (input valid, func, corner_a, corner_b, corner_c, corner_d,
                 read_index, output ready);
endinterface

interface mvr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [12:0] face_start;
   logic [12:0] face_count;
   logic [13:0] neighbor_start;
   logic [13:0] neighbor_count;
   logic        on_edge;
   logic [9:0]  ring_entry;
   logic [12:0] face_total;
   logic [13:0] neighbor_total;

   modport source (output valid, status, face_start, face_count, neighbor_start,
                   neighbor_count, on_edge, ring_entry, face_total, neighbor_total,
                   input ready);
   modport sink (input valid, status, face_start, face_count, neighbor_start,
                 neighbor_count, on_edge, ring_entry, face_total, neighbor_total,
                 output ready);
endinterface

>>> design/mesh_vertex_ring_builder.sv
// Top level of the mesh vertex ring builder: configuration register port,
// front end and back end. Uses mvr_pkg, mvr_chan_if, mvr_front and mvr_back.
//
// Faces are loaded one per request word and a build request turns them into
// per-vertex face rings and sorted, duplicate-free neighbor rings. Requests are
// queued two deep and handled one at a time by the back end.
// A build is run by the memory sequencer, one memory access per step: it clears
// the counters of the nv vertices, counts each face's corners, turns the counts
// into running offsets in a prefix pass and files each face under its corners,
// then clears the counters again and counts, offsets and files each edge end the
// same way; last, for each vertex it stamps its raw neighbors and scans from the
// lowest to the highest of them, where nv is min(vert_count, MAX_VERTS).
// No clearing pass runs after reset.
module mesh_vertex_ring_builder
   import mvr_pkg::*;
#(
   parameter int MAX_VERTS = 1024,
   parameter int MAX_FACES = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   mvr_req_if.sink     req_chan,
   mvr_rsp_if.source   rsp_chan
);

   localparam logic REG_VERT_COUNT = 1'b0;

   logic [10:0] vert_count_ff, vert_count_in;
   logic        csr_write;
   cmd_type     cmd;
   logic        cmd_valid;
   logic        cmd_ready;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      vert_count_in = vert_count_ff;
      if (csr_write && paddr[2] == REG_VERT_COUNT) begin
         vert_count_in = pwdata[10:0];
      end
      prdata = (paddr[2] == REG_VERT_COUNT) ? 32'(vert_count_ff) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vert_count_ff <= 11'd0;
      end else begin
         vert_count_ff <= vert_count_in;
      end
   end

   mvr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   mvr_back #(
      .MAX_VERTS (MAX_VERTS),
      .MAX_FACES (MAX_FACES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .vert_count (vert_count_ff),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> design/mvr_front.sv
// Front end: accepts request words, decodes the function code into an
// operation and queues the commands for the back end. Uses mvr_pkg, mvr_req_if.
module mvr_front
   import mvr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mvr_req_if.sink   req_chan,
   output cmd_type   cmd,
   output logic      cmd_valid,
   input  logic      cmd_ready
);

   localparam int QDEPTH = 2;

   cmd_type     q_ff [QDEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;
   cmd_type     dec;

   always_comb begin
      dec.corner_a   = req_chan.corner_a;
      dec.corner_b   = req_chan.corner_b;
      dec.corner_c   = req_chan.corner_c;
      dec.corner_d   = req_chan.corner_d;
      dec.read_index = req_chan.read_index;
      unique case (req_chan.func)
         FUNC_LOAD:    dec.op = OP_LOAD;
         FUNC_BUILD:   dec.op = OP_BUILD;
         FUNC_RD_VERT: dec.op = OP_RD_VERT;
         FUNC_RD_FACE: dec.op = OP_RD_FACE;
         FUNC_RD_NB:   dec.op = OP_RD_NB;
         FUNC_CLEAR:   dec.op = OP_CLEAR;
         default:      dec.op = OP_NOP;
      endcase
   end

   assign req_chan.ready = (cnt_ff != 2'(QDEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDEPTH))
      else $error("command queue holds more than its depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'(QDEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with the fill count");

   a_pop_order: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rd_ptr_ff != $past(rd_ptr_ff)))
      else $error("read pointer did not advance after a pop");

endmodule

>>> design/mvr_back.sv
// Back end: stores faces, runs the table build sequencer and answers reads.
// All tables live in memories with one write and one registered read port. Uses mvr_pkg, mvr_rsp_if.
module mvr_back
   import mvr_pkg::*;
#(
   parameter int MAX_VERTS = 1024,
   parameter int MAX_FACES = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [10:0] vert_count,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   mvr_rsp_if.source   rsp_chan
);

   localparam int VW  = $clog2(MAX_VERTS);
   localparam int NVW = $clog2(MAX_VERTS + 1);
   localparam int FW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int NFW = $clog2(MAX_FACES + 1);
   localparam int FRD = 4 * MAX_FACES;
   localparam int NRD = 8 * MAX_FACES;
   localparam int FRA = $clog2(FRD);
   localparam int NRA = $clog2(NRD);
   localparam int FTW = $clog2(FRD + 1);
   localparam int NTW = $clog2(NRD + 1);

   bld_state_type state_ff, state_in;
   pass_type      mode_ff, mode_in;
   cmd_type       cmd_ff, cmd_in;
   logic [NFW-1:0] nfaces_ff, nfaces_in;
   logic           built_ff, built_in;
   logic [NVW-1:0] nv_ff, nv_in;
   logic [FTW-1:0] ftot_ff, ftot_in;
   logic [NTW-1:0] ntot_ff, ntot_in;
   logic [NVW-1:0] v_ff, v_in;
   logic [NFW-1:0] f_ff, f_in;
   logic [2:0]     k_ff, k_in;
   logic [NTW-1:0] tot_ff, tot_in;
   logic [NTW-1:0] start_ff, start_in;
   logic [FTW-1:0] fcnt_i_ff, fcnt_i_in;
   logic [NTW-1:0] roff_ff, roff_in;
   logic [NTW-1:0] rcnt_ff, rcnt_in;
   logic [NTW-1:0] k2_ff, k2_in;
   logic [VW-1:0]  lo_ff, lo_in;
   logic [VW-1:0]  hi_ff, hi_in;
   logic [VW-1:0]  s_ff, s_in;
   logic           any_ff, any_in;
   res_type        res_ff, res_in;
   res_type        rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Memories and their registered read data.
   logic [127:0]      face_mem [MAX_FACES];
   logic [127:0]      face_rd_ff;
   logic [NTW-1:0]    head_mem [MAX_VERTS];
   logic [NTW-1:0]    head_rd_ff;
   logic [2*FTW-1:0]  fmem [MAX_VERTS];
   logic [2*FTW-1:0]  fmem_rd_ff;
   logic [2*NTW-1:0]  rmem [MAX_VERTS];
   logic [2*NTW-1:0]  rmem_rd_ff;
   logic [2*NTW:0]    nmem [MAX_VERTS];
   logic [2*NTW:0]    nmem_rd_ff;
   logic [NVW-1:0]    seen_mem [MAX_VERTS];
   logic [NVW-1:0]    seen_rd_ff;
   logic [FW-1:0]     fring_mem [FRD];
   logic [FW-1:0]     fring_rd_ff;
   logic [VW-1:0]     raw_mem [NRD];
   logic [VW-1:0]     raw_rd_ff;
   logic [VW-1:0]     nring_mem [NRD];
   logic [VW-1:0]     nring_rd_ff;

   logic              face_we;
   logic [127:0]      face_wd;
   logic              head_we;
   logic [VW-1:0]     head_wa, head_ra;
   logic [NTW-1:0]    head_wd;
   logic              fmem_we;
   logic [2*FTW-1:0]  fmem_wd;
   logic [VW-1:0]     fmem_ra;
   logic              rmem_we;
   logic [2*NTW-1:0]  rmem_wd;
   logic              nmem_we;
   logic [2*NTW:0]    nmem_wd;
   logic              seen_we;
   logic [VW-1:0]     seen_wa;
   logic [NVW-1:0]    seen_wd;
   logic              fring_we;
   logic              raw_we;
   logic [VW-1:0]     raw_wd;
   logic              nring_we;

   // Corner walk decode.
   logic [31:0] corner [4];
   logic        edge_mode, face_is_tri, last_op, op_valid;
   logic [3:0]  op_count;
   logic [1:0]  j_idx, jn_idx;
   logic [31:0] ea, eb, t32, o32, nv32;
   logic [VW-1:0] tgt, oth;
   logic [NVW-1:0] nv_calc, stamp;
   logic [NTW-1:0] uniq;

   function automatic res_type blank_res(status_type st, logic bl,
                                         logic [FTW-1:0] ft, logic [NTW-1:0] nt);
      res_type r;
      r = '0;
      r.status = st;
      r.face_total = bl ? 13'(ft) : 13'd0;
      r.neighbor_total = bl ? 14'(nt) : 14'd0;
      return r;
   endfunction

   always_comb begin
      corner[0] = face_rd_ff[31:0];
      corner[1] = face_rd_ff[63:32];
      corner[2] = face_rd_ff[95:64];
      corner[3] = face_rd_ff[127:96];
      edge_mode = (mode_ff == P_RCOUNT) || (mode_ff == P_RFILL);
      face_is_tri = (face_rd_ff[127:96] == TRI_MARK);
      op_count = edge_mode ? (face_is_tri ? 4'd6 : 4'd8) : 4'd4;
      last_op = ({1'b0, k_ff} == (op_count - 4'd1));
      j_idx = k_ff[2:1];
      jn_idx = (face_is_tri && j_idx == 2'd2) ? 2'd0 : j_idx + 2'd1;
      ea = corner[j_idx];
      eb = corner[jn_idx];
      nv32 = 32'(nv_ff);
      if (edge_mode) begin
         // Even steps file the far end under the near end, odd steps the reverse.
         t32 = k_ff[0] ? eb : ea;
         o32 = k_ff[0] ? ea : eb;
         op_valid = (ea < nv32) && (eb < nv32);
      end else begin
         t32 = corner[k_ff[1:0]];
         o32 = t32;
         op_valid = (t32 < nv32);
      end
      tgt = VW'(t32);
      oth = VW'(o32);
      nv_calc = (32'(vert_count) > MAX_VERTS) ? NVW'(MAX_VERTS) : NVW'(vert_count);
      stamp = NVW'(v_ff + 1'b1);
      uniq = tot_ff - start_ff;
   end

   assign cmd_ready = (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_LOAD:  state_in = ST_LOAD;
                  OP_BUILD: state_in = ST_CLR;
                  OP_RD_VERT, OP_RD_FACE, OP_RD_NB: state_in = ST_RD_ISSUE;
                  default:  state_in = ST_FIN;
               endcase
            end
         end
         ST_LOAD:     state_in = ST_FIN;
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA:  state_in = ST_FIN;
         ST_CLR:      state_in = (v_ff < nv_ff) ? ST_CLR : ST_FACE_RD;
         ST_FACE_RD: begin
            if (f_ff < nfaces_ff) begin
               state_in = ST_OP_RD;
            end else begin
               unique case (mode_ff)
                  P_FCOUNT: state_in = ST_PFX_RD;
                  P_FFILL:  state_in = ST_CLR;
                  P_RCOUNT: state_in = ST_PFX_RD;
                  default:  state_in = ST_DD_RD;
               endcase
            end
         end
         ST_OP_RD: begin
            if (op_valid) begin
               state_in = ST_OP_WR;
            end else begin
               state_in = last_op ? ST_FACE_RD : ST_OP_RD;
            end
         end
         ST_OP_WR:    state_in = last_op ? ST_FACE_RD : ST_OP_RD;
         ST_PFX_RD:   state_in = (v_ff < nv_ff) ? ST_PFX_WR : ST_FACE_RD;
         ST_PFX_WR:   state_in = ST_PFX_RD;
         ST_DD_RD:    state_in = (v_ff < nv_ff) ? ST_DD_LATCH : ST_FIN;
         ST_DD_LATCH: state_in = ST_MK_RD;
         ST_MK_RD: begin
            if (k2_ff < rcnt_ff) begin
               state_in = ST_MK_WR;
            end else begin
               state_in = any_ff ? ST_SC_RD : ST_DD_WR;
            end
         end
         ST_MK_WR:    state_in = ST_MK_RD;
         ST_SC_RD:    state_in = ST_SC_WR;
         ST_SC_WR:    state_in = (s_ff == hi_ff) ? ST_DD_WR : ST_SC_RD;
         ST_DD_WR:    state_in = ST_DD_RD;
         ST_FIN:      state_in = (!rsp_valid_ff || rsp_chan.ready) ? ST_IDLE : ST_FIN;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      mode_in = mode_ff;
      cmd_in = cmd_ff;
      nfaces_in = nfaces_ff;
      built_in = built_ff;
      nv_in = nv_ff;
      ftot_in = ftot_ff;
      ntot_in = ntot_ff;
      v_in = v_ff;
      f_in = f_ff;
      k_in = k_ff;
      tot_in = tot_ff;
      start_in = start_ff;
      fcnt_i_in = fcnt_i_ff;
      roff_in = roff_ff;
      rcnt_in = rcnt_ff;
      k2_in = k2_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      s_in = s_ff;
      any_in = any_ff;
      res_in = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      face_we = 1'b0;
      face_wd = {cmd_ff.corner_d, cmd_ff.corner_c, cmd_ff.corner_b, cmd_ff.corner_a};
      head_we = 1'b0;
      head_wa = tgt;
      head_wd = head_rd_ff + 1'b1;
      fmem_we = 1'b0;
      fmem_wd = {FTW'(tot_ff), FTW'(head_rd_ff)};
      rmem_we = 1'b0;
      rmem_wd = {tot_ff, head_rd_ff};
      nmem_we = 1'b0;
      nmem_wd = {start_ff, uniq, (NTW'(fcnt_i_ff) != uniq)};
      seen_we = 1'b0;
      seen_wa = raw_rd_ff;
      seen_wd = stamp;
      fring_we = 1'b0;
      raw_we = 1'b0;
      raw_wd = oth;
      nring_we = 1'b0;

      head_ra = (state_ff == ST_PFX_RD) ? VW'(v_ff) : tgt;
      fmem_ra = (state_ff == ST_DD_RD) ? VW'(v_ff) : VW'(cmd_ff.read_index);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               unique case (cmd.op)
                  OP_BUILD: begin
                     mode_in = P_FCOUNT;
                     v_in = '0;
                     nv_in = nv_calc;
                  end
                  OP_CLEAR: begin
                     nfaces_in = '0;
                     built_in = 1'b0;
                     res_in = blank_res(STAT_OK, 1'b0, ftot_ff, ntot_ff);
                  end
                  OP_NOP: res_in = blank_res(STAT_OK, built_ff, ftot_ff, ntot_ff);
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            if (nfaces_ff == NFW'(MAX_FACES)) begin
               res_in = blank_res(STAT_FULL, built_ff, ftot_ff, ntot_ff);
            end else begin
               face_we = 1'b1;
               nfaces_in = nfaces_ff + 1'b1;
               built_in = 1'b0;
               res_in = blank_res(STAT_OK, 1'b0, ftot_ff, ntot_ff);
            end
         end
         ST_RD_ISSUE: ;
         ST_RD_DATA: begin
            res_in = blank_res(STAT_OK, built_ff, ftot_ff, ntot_ff);
            if (!built_ff) begin
               res_in.status = STAT_NOT_BUILT;
            end else begin
               unique case (cmd_ff.op)
                  OP_RD_VERT: begin
                     if (32'(cmd_ff.read_index) >= 32'(nv_ff)) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        res_in.face_start = 13'(fmem_rd_ff[2*FTW-1:FTW]);
                        res_in.face_count = 13'(fmem_rd_ff[FTW-1:0]);
                        res_in.neighbor_start = 14'(nmem_rd_ff[2*NTW:NTW+1]);
                        res_in.neighbor_count = 14'(nmem_rd_ff[NTW:1]);
                        res_in.on_edge = nmem_rd_ff[0];
                     end
                  end
                  OP_RD_FACE: begin
                     if (32'(cmd_ff.read_index) >= 32'(ftot_ff)) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        res_in.ring_entry = 10'(fring_rd_ff);
                     end
                  end
                  default: begin
                     if (32'(cmd_ff.read_index) >= 32'(ntot_ff)) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        res_in.ring_entry = 10'(nring_rd_ff);
                     end
                  end
               endcase
            end
         end
         ST_CLR: begin
            if (v_ff < nv_ff) begin
               head_we = 1'b1;
               head_wa = VW'(v_ff);
               head_wd = '0;
               seen_we = 1'b1;
               seen_wa = VW'(v_ff);
               seen_wd = '0;
               v_in = v_ff + 1'b1;
            end else begin
               v_in = '0;
               f_in = '0;
               k_in = '0;
            end
         end
         ST_FACE_RD: begin
            if (f_ff >= nfaces_ff) begin
               v_in = '0;
               tot_in = '0;
               if (mode_ff == P_FFILL) begin
                  mode_in = P_RCOUNT;
               end
            end
         end
         ST_OP_RD: begin
            if (!op_valid) begin
               if (last_op) begin
                  k_in = '0;
                  f_in = f_ff + 1'b1;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_OP_WR: begin
            head_we = 1'b1;
            if (mode_ff == P_FFILL) begin
               fring_we = 1'b1;
            end
            if (mode_ff == P_RFILL) begin
               raw_we = 1'b1;
            end
            if (last_op) begin
               k_in = '0;
               f_in = f_ff + 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_PFX_RD: begin
            if (v_ff >= nv_ff) begin
               f_in = '0;
               k_in = '0;
               if (mode_ff == P_FCOUNT) begin
                  ftot_in = FTW'(tot_ff);
                  mode_in = P_FFILL;
               end else begin
                  mode_in = P_RFILL;
               end
            end
         end
         ST_PFX_WR: begin
            // Counts become running offsets, which the fill pass then uses as heads.
            head_we = 1'b1;
            head_wa = VW'(v_ff);
            head_wd = tot_ff;
            fmem_we = (mode_ff == P_FCOUNT);
            rmem_we = (mode_ff != P_FCOUNT);
            tot_in = tot_ff + head_rd_ff;
            v_in = v_ff + 1'b1;
         end
         ST_DD_RD: begin
            if (v_ff >= nv_ff) begin
               ntot_in = tot_ff;
               built_in = 1'b1;
               res_in = blank_res(STAT_OK, 1'b1, ftot_ff, tot_ff);
            end
         end
         ST_DD_LATCH: begin
            fcnt_i_in = fmem_rd_ff[FTW-1:0];
            roff_in = rmem_rd_ff[2*NTW-1:NTW];
            rcnt_in = rmem_rd_ff[NTW-1:0];
            k2_in = '0;
            start_in = tot_ff;
            any_in = 1'b0;
         end
         ST_MK_RD: begin
            if (k2_ff >= rcnt_ff && any_ff) begin
               s_in = lo_ff;
            end
         end
         ST_MK_WR: begin
            // Stamp each raw neighbor; the stamp is unique to this vertex.
            seen_we = 1'b1;
            if (!any_ff || raw_rd_ff < lo_ff) begin
               lo_in = raw_rd_ff;
            end
            if (!any_ff || raw_rd_ff > hi_ff) begin
               hi_in = raw_rd_ff;
            end
            any_in = 1'b1;
            k2_in = k2_ff + 1'b1;
         end
         ST_SC_RD: ;
         ST_SC_WR: begin
            if (seen_rd_ff == stamp) begin
               nring_we = 1'b1;
               tot_in = tot_ff + 1'b1;
            end
            if (s_ff != hi_ff) begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_DD_WR: begin
            nmem_we = 1'b1;
            v_in = v_ff + 1'b1;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (face_we) begin
         face_mem[FW'(nfaces_ff)] <= face_wd;
      end
      face_rd_ff <= face_mem[FW'(f_ff)];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd_ff <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (fmem_we) begin
         fmem[VW'(v_ff)] <= fmem_wd;
      end
      fmem_rd_ff <= fmem[fmem_ra];
   end

   always_ff @(posedge clock) begin
      if (rmem_we) begin
         rmem[VW'(v_ff)] <= rmem_wd;
      end
      rmem_rd_ff <= rmem[VW'(v_ff)];
   end

   always_ff @(posedge clock) begin
      if (nmem_we) begin
         nmem[VW'(v_ff)] <= nmem_wd;
      end
      nmem_rd_ff <= nmem[VW'(cmd_ff.read_index)];
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_wa] <= seen_wd;
      end
      seen_rd_ff <= seen_mem[s_ff];
   end

   always_ff @(posedge clock) begin
      if (fring_we) begin
         fring_mem[FRA'(head_rd_ff)] <= FW'(f_ff);
      end
      fring_rd_ff <= fring_mem[FRA'(cmd_ff.read_index)];
   end

   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_mem[NRA'(head_rd_ff)] <= raw_wd;
      end
      raw_rd_ff <= raw_mem[NRA'(roff_ff + k2_ff)];
   end

   always_ff @(posedge clock) begin
      if (nring_we) begin
         nring_mem[NRA'(tot_ff)] <= s_ff;
      end
      nring_rd_ff <= nring_mem[NRA'(cmd_ff.read_index)];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      nv_ff <= nv_in;
      ftot_ff <= ftot_in;
      ntot_ff <= ntot_in;
      v_ff <= v_in;
      f_ff <= f_in;
      k_ff <= k_in;
      tot_ff <= tot_in;
      start_ff <= start_in;
      fcnt_i_ff <= fcnt_i_in;
      roff_ff <= roff_in;
      rcnt_ff <= rcnt_in;
      k2_ff <= k2_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      s_ff <= s_in;
      any_ff <= any_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
      mode_ff <= mode_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nfaces_ff <= '0;
         built_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nfaces_ff <= nfaces_in;
         built_ff <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.face_start     = rsp_data_ff.face_start;
   assign rsp_chan.face_count     = rsp_data_ff.face_count;
   assign rsp_chan.neighbor_start = rsp_data_ff.neighbor_start;
   assign rsp_chan.neighbor_count = rsp_data_ff.neighbor_count;
   assign rsp_chan.on_edge        = rsp_data_ff.on_edge;
   assign rsp_chan.ring_entry     = rsp_data_ff.ring_entry;
   assign rsp_chan.face_total     = rsp_data_ff.face_total;
   assign rsp_chan.neighbor_total = rsp_data_ff.neighbor_total;

   a_face_bound: assert property (@(posedge clock) disable iff (reset)
      nfaces_ff <= NFW'(MAX_FACES))
      else $error("face count exceeds the face store");

   a_load_stale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && nfaces_ff != NFW'(MAX_FACES)) |=> !built_ff)
      else $error("tables still marked built after a face load");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the delivery state");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OP_WR && mode_ff == P_FFILL) |-> (32'(head_rd_ff) < FRD))
      else $error("face ring head beyond its capacity");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC_WR) |-> (s_ff >= lo_ff && s_ff <= hi_ff))
      else $error("neighbor scan left its marked range");

endmodule
